// ----- src/emc_pkg.sv -----
// Shared constants, types and helper functions of the executable machine classifier.
package emc_pkg;

	localparam int COUNT_BITS_DEF = 33;

	// Header offsets that the decision reads.
	localparam int PE_PTR_POS   = 'h3C;
	localparam int CAPTURE_FROM = 'h40;
	localparam int HI_BASE      = 'h3B;
	localparam int HI_SLOTS     = 5;
	localparam int LO_SLOTS     = 7;
	localparam int WIN_BYTES    = 6;
	localparam int ELF_MIN      = 20;
	localparam int MIN_BYTES    = 4;

	// Slots of the low header bytes and the file offsets they hold.
	localparam int SLOT_H0  = 0;
	localparam int SLOT_H1  = 1;
	localparam int SLOT_H2  = 2;
	localparam int SLOT_H3  = 3;
	localparam int SLOT_H5  = 4;
	localparam int SLOT_H18 = 5;
	localparam int SLOT_H19 = 6;
	localparam logic [5:0] LO_POS [LO_SLOTS] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd18, 6'd19};

	localparam logic [7:0] MZ_0      = 8'h4D;
	localparam logic [7:0] MZ_1      = 8'h5A;
	localparam logic [7:0] ELF_0     = 8'h7F;
	localparam logic [7:0] ELF_1     = 8'h45;
	localparam logic [7:0] ELF_2     = 8'h4C;
	localparam logic [7:0] ELF_3     = 8'h46;
	localparam logic [7:0] ELF_BE    = 8'h02;
	localparam logic [7:0] PE_P      = 8'h50;
	localparam logic [7:0] PE_E      = 8'h45;
	localparam logic [15:0] MACH_I386    = 16'h014C;
	localparam logic [15:0] MACH_AMD64   = 16'h8664;
	localparam logic [15:0] ELF_MACH_386 = 16'd3;
	localparam logic [15:0] ELF_MACH_X64 = 16'd62;

	// Snapshot of the tracked file state after the current byte.
	typedef struct packed {
		logic [LO_SLOTS-1:0][7:0] lo;
		logic [HI_SLOTS-1:0][7:0] hi;
		logic [31:0]              pe_off;
		logic [47:0]              window;
		logic [63:0]              flags;
		logic                     n_lt4;
		logic                     n_ge20;
		logic                     n_ge64;
		logic                     pe_fits;
	} emc_view_t;

	// True when six bytes hold a PE signature with a machine other than x86.
	function automatic logic pe_reject(input logic [WIN_BYTES-1:0][7:0] b);
		logic        sig;
		logic [15:0] m;
		sig = (b[0] == PE_P) && (b[1] == PE_E) && (b[2] == 8'h00) && (b[3] == 8'h00);
		m   = {b[5], b[4]};
		return sig && !((m == MACH_I386) || (m == MACH_AMD64));
	endfunction

endpackage

// ----- src/emc_track.sv -----
// Byte counter, header capture, PE flag line and PE window of the classifier.
module emc_track #(
	parameter int COUNT_BITS = emc_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                final_byte,
	output emc_pkg::emc_view_t  view
);

	localparam int CMP_W = (COUNT_BITS > 33) ? COUNT_BITS : 33;

	logic [COUNT_BITS-1:0] count_q, count_nx;
	logic [47:0]           window_q, window_nx;
	logic [emc_pkg::LO_SLOTS-1:0][7:0] lo_q, lo_nx;
	logic [emc_pkg::HI_SLOTS-1:0][7:0] hi_q, hi_nx;
	logic [4:0][7:0]       shift_q;
	logic [63:0]           flags_q, flags_nx;

	logic             below_max, low_zone;
	logic [5:0]       pos6, flag_idx;
	logic [31:0]      pe_off;
	logic [CMP_W-1:0] idx_w, off_w, n_w, span;
	logic             cap;

	assign below_max = ~&count_q;
	assign low_zone  = (count_q[COUNT_BITS-1:6] == '0);
	assign pos6      = count_q[5:0];
	assign count_nx  = below_max ? count_q + COUNT_BITS'(1) : count_q;
	assign flag_idx  = pos6 - 6'd5;

	always_comb begin
		for (int i = 0; i < emc_pkg::LO_SLOTS; i++) begin
			lo_nx[i] = (below_max && low_zone && pos6 == emc_pkg::LO_POS[i]) ? data_byte : lo_q[i];
		end
		for (int i = 0; i < emc_pkg::HI_SLOTS; i++) begin
			hi_nx[i] = (below_max && low_zone && pos6 == 6'(emc_pkg::HI_BASE + i))
				? data_byte : hi_q[i];
		end
	end

	// Offset bytes 0x3C..0x3F sit in the upper four high slots.
	assign pe_off = {hi_nx[4], hi_nx[3], hi_nx[2], hi_nx[1]};

	// Each start position whose six bytes all lie below the capture zone gets its reject flag once its
	// sixth byte arrives; the five previous bytes come from the shift line.
	always_comb begin
		flags_nx = flags_q;
		if (below_max && low_zone && pos6 >= 6'd5) begin
			flags_nx[flag_idx] = emc_pkg::pe_reject({data_byte, shift_q[0], shift_q[1],
				shift_q[2], shift_q[3], shift_q[4]});
		end
	end

	assign idx_w = CMP_W'(count_q);
	assign off_w = CMP_W'(pe_off);
	assign n_w   = CMP_W'(count_nx);
	assign span  = idx_w - off_w;
	assign cap   = below_max && !low_zone && (idx_w >= off_w) && (span < CMP_W'(6));

	always_comb begin
		window_nx = window_q;
		if (cap) begin
			window_nx[8*span[2:0] +: 8] = data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			window_q <= '0;
		end else if (step) begin
			count_q  <= final_byte ? '0 : count_nx;
			window_q <= final_byte ? '0 : window_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			lo_q    <= lo_nx;
			hi_q    <= hi_nx;
			flags_q <= flags_nx;
			shift_q <= {shift_q[3:0], data_byte};
		end
	end

	always_comb begin
		view.lo      = lo_nx;
		view.hi      = hi_nx;
		view.pe_off  = pe_off;
		view.window  = window_nx;
		view.flags   = flags_nx;
		view.n_lt4   = count_nx < COUNT_BITS'(emc_pkg::MIN_BYTES);
		view.n_ge20  = count_nx >= COUNT_BITS'(emc_pkg::ELF_MIN);
		view.n_ge64  = count_nx >= COUNT_BITS'(emc_pkg::CAPTURE_FROM);
		view.pe_fits = (off_w + CMP_W'(6)) <= n_w;
	end

endmodule

// ----- src/emc_decide.sv -----
// Bucket decision from the tracked header, PE flags and PE window.
module emc_decide (
	input  emc_pkg::emc_view_t view,
	output logic               bucket
);

	logic [emc_pkg::WIN_BYTES-1:0][7:0] pe_b;
	logic [32:0] pos [emc_pkg::WIN_BYTES];
	logic [2:0]  hsel [emc_pkg::WIN_BYTES];
	logic        low_start, rej, is_mz, is_elf;
	logic [15:0] elf_m;

	// Starts up to 0x3A lie wholly below the capture zone and use the flag line.
	assign low_start = (view.pe_off[31:6] == '0) && (view.pe_off[5:0] < 6'(emc_pkg::HI_BASE));

	always_comb begin
		for (int k = 0; k < emc_pkg::WIN_BYTES; k++) begin
			pos[k]  = {1'b0, view.pe_off} + 33'(k);
			hsel[k] = 3'(pos[k][5:0] - 6'(emc_pkg::HI_BASE));
			if (pos[k] < 33'(emc_pkg::CAPTURE_FROM)) begin
				case (hsel[k])
					3'd0:    pe_b[k] = view.hi[0];
					3'd1:    pe_b[k] = view.hi[1];
					3'd2:    pe_b[k] = view.hi[2];
					3'd3:    pe_b[k] = view.hi[3];
					3'd4:    pe_b[k] = view.hi[4];
					default: pe_b[k] = 8'h00;
				endcase
			end else begin
				pe_b[k] = view.window[8*k +: 8];
			end
		end
	end

	assign rej = low_start ? view.flags[view.pe_off[5:0]] : emc_pkg::pe_reject(pe_b);

	assign is_mz  = (view.lo[emc_pkg::SLOT_H0] == emc_pkg::MZ_0)
		&& (view.lo[emc_pkg::SLOT_H1] == emc_pkg::MZ_1);
	assign is_elf = (view.lo[emc_pkg::SLOT_H0] == emc_pkg::ELF_0)
		&& (view.lo[emc_pkg::SLOT_H1] == emc_pkg::ELF_1)
		&& (view.lo[emc_pkg::SLOT_H2] == emc_pkg::ELF_2)
		&& (view.lo[emc_pkg::SLOT_H3] == emc_pkg::ELF_3);
	assign elf_m = (view.lo[emc_pkg::SLOT_H5] == emc_pkg::ELF_BE)
		? {view.lo[emc_pkg::SLOT_H18], view.lo[emc_pkg::SLOT_H19]}
		: {view.lo[emc_pkg::SLOT_H19], view.lo[emc_pkg::SLOT_H18]};

	always_comb begin
		if (view.n_lt4) begin
			bucket = 1'b0;
		end else if (is_mz) begin
			bucket = !(view.n_ge64 && view.pe_fits && rej);
		end else if (is_elf) begin
			bucket = !view.n_ge20 || (elf_m == emc_pkg::ELF_MACH_386)
				|| (elf_m == emc_pkg::ELF_MACH_X64);
		end else begin
			bucket = 1'b0;
		end
	end

endmodule

// ----- src/executable_machine_classifier.sv -----
// Top level of the executable machine classifier: input stage, tracker, decision, result register.
//
// The s_ channel carries a file one byte per word, from offset zero, with
// s_tlast on the final byte. For each file the m_ channel returns one word
// whose bit 0 is the bucket: 1 for an MZ or ELF file of at least four bytes
// unless its header names a non-x86 machine, else 0. Non-final bytes produce no output word.
// Throughput is one byte per cycle while s_tready stays high: every byte
// passes an input register and one pass of header tracking and decision
// logic; the result sits in its own register, which drives m_.
// While a result waits on m_tready, bytes of the next file keep flowing;
// only a second final byte holds in the input register until the waiting
// result is taken, and s_tready then drops.
// Reset clears the byte counter, the PE window and both valid flags. Header
// bytes are rewritten by each file before the decision reads them.
// The byte counter saturates at its maximum; later bytes are ignored.
module executable_machine_classifier #(
	parameter int COUNT_BITS = emc_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // final_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] bucket, [7:1] zero
);

	logic       vld_s1, last_s1, adv;
	logic [7:0] byte_s1;
	logic       res_vld_q, bucket_q, bucket;
	emc_pkg::emc_view_t view;

	assign adv      = vld_s1 && (!last_s1 || !res_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	emc_track #(
		.COUNT_BITS(COUNT_BITS)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.data_byte  (byte_s1),
		.final_byte (last_s1),
		.view       (view)
	);

	emc_decide u_decide (
		.view   (view),
		.bucket (bucket)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_vld_q <= 1'b1;
		end else if (m_tready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			bucket_q <= bucket;
		end
	end

	assign m_tvalid = res_vld_q;
	assign m_tdata  = {7'b0, bucket_q};

	// A new result word only follows a final byte passing the tracker.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv && last_s1))
		else $error("result word without a processed final byte");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while stalled");

	// Input stalls only for a final byte blocked behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && last_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a blocked final byte");

endmodule

// ----- tb/bucket_checker.sv -----
// Checker that predicts the bucket bit of each file and compares it with the result channel.
module bucket_checker #(
	parameter int COUNT_BITS = emc_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // final_byte
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [0] bucket, [7:1] zero
	output int         fail_count,
	output int         pending
);

	localparam int HDR_BYTES = 72;
	localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - COUNT_BITS);

	logic [63:0] seen_bytes = '0;
	logic [7:0]  hdr [HDR_BYTES];
	logic [47:0] pe_win = '0;
	logic        bucket_q [$];
	logic [63:0] idx;
	logic [31:0] ptr_now;
	logic        want_bucket;

	function automatic logic [31:0] pe_pointer();
		return {hdr[emc_pkg::PE_PTR_POS+3], hdr[emc_pkg::PE_PTR_POS+2],
			hdr[emc_pkg::PE_PTR_POS+1], hdr[emc_pkg::PE_PTR_POS]};
	endfunction

	// PE bytes below the capture offset still sit in the header; the rest were captured.
	function automatic logic [7:0] pe_area_byte(input logic [31:0] off, input int k);
		logic [63:0] pos;
		pos = {32'd0, off} + 64'(k);
		if (pos < emc_pkg::CAPTURE_FROM && pos < HDR_BYTES)
			return hdr[pos[6:0]];
		return pe_win[8*k +: 8];
	endfunction

	function automatic logic classify_file(input logic [63:0] n);
		logic [31:0] off;
		logic [15:0] mach;
		if (n < emc_pkg::MIN_BYTES)
			return 1'b0;
		if (hdr[0] == emc_pkg::MZ_0 && hdr[1] == emc_pkg::MZ_1) begin
			if (n >= emc_pkg::CAPTURE_FROM) begin
				off = pe_pointer();
				if ({32'd0, off} + 64'd6 <= n &&
				    pe_area_byte(off, 0) == emc_pkg::PE_P &&
				    pe_area_byte(off, 1) == emc_pkg::PE_E &&
				    pe_area_byte(off, 2) == 8'h00 && pe_area_byte(off, 3) == 8'h00) begin
					mach = {pe_area_byte(off, 5), pe_area_byte(off, 4)};
					return (mach == emc_pkg::MACH_I386) || (mach == emc_pkg::MACH_AMD64);
				end
			end
			return 1'b1;
		end
		if (hdr[0] == emc_pkg::ELF_0 && hdr[1] == emc_pkg::ELF_1 &&
		    hdr[2] == emc_pkg::ELF_2 && hdr[3] == emc_pkg::ELF_3) begin
			if (n >= emc_pkg::ELF_MIN) begin
				mach = (hdr[5] == emc_pkg::ELF_BE) ? {hdr[18], hdr[19]} : {hdr[19], hdr[18]};
				return (mach == emc_pkg::ELF_MACH_386) || (mach == emc_pkg::ELF_MACH_X64);
			end
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] want,
	                             input logic [7:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_bytes = '0;
			pe_win = '0;
			bucket_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// The result side goes first so that a word taken at this edge is never
			// matched against a file that closes at the same edge.
			if (m_tvalid && m_tready) begin
				if (bucket_q.size() == 0) begin
					flag_mismatch("unexpected result word", 8'hxx, m_tdata);
				end else begin
					want_bucket = bucket_q.pop_front();
					if (m_tdata[0] !== want_bucket)
						flag_mismatch("bucket", {7'd0, want_bucket}, {7'd0, m_tdata[0]});
					if (m_tdata[7:1] !== 7'd0)
						flag_mismatch("padding bits", 8'h00, {1'b0, m_tdata[7:1]});
				end
			end
			if (s_tvalid && s_tready) begin
				idx = seen_bytes;
				if (idx < COUNT_MAX) begin
					if (idx < HDR_BYTES)
						hdr[idx[6:0]] = s_tdata;
					if (idx >= emc_pkg::CAPTURE_FROM) begin
						ptr_now = pe_pointer();
						if (idx >= {32'd0, ptr_now} &&
						    idx - {32'd0, ptr_now} < emc_pkg::WIN_BYTES)
							pe_win[8*(idx - {32'd0, ptr_now}) +: 8] = s_tdata;
					end
					seen_bytes = idx + 64'd1;
				end
				if (s_tlast) begin
					bucket_q.push_back(classify_file(seen_bytes));
					seen_bytes = '0;
					pe_win = '0;
				end
			end
			pending <= bucket_q.size();
		end
	end

endmodule

// ----- tb/executable_machine_classifier_tb.sv -----
// Testbench top: feeds files into the classifier, stalls the result side and gives the verdict.
module executable_machine_classifier_tb;

	localparam int COUNT_BITS = emc_pkg::COUNT_BITS_DEF;
	localparam logic [7:0] ELF_LE = 8'h01;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tready = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	int         fail_count;
	int         pending;

	logic [7:0]  frame [$];
	bit          tx_steady;
	bit          rx_steady;
	int unsigned stall_left = 0;
	int unsigned stall_next;
	int unsigned bytes_sent = 0;
	int unsigned files_sent = 0;

	always #5 clk = ~clk;

	executable_machine_classifier #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bucket_checker #(.COUNT_BITS(COUNT_BITS)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Result side: a stall follows some words taken, and some start while idle.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if ($urandom_range(0, 15) == 0)
				rx_steady = !rx_steady;
			stall_next = rx_steady ? 0 : $urandom_range(0, 13);
		end else if (stall_left > 0) begin
			stall_next = stall_left - 1;
		end else if (!rx_steady && $urandom_range(0, 15) == 0) begin
			stall_next = $urandom_range(1, 13);
		end else begin
			stall_next = 0;
		end
		stall_left <= stall_next;
		m_tready <= (stall_next == 0);
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++)
			send_word(frame[i], i == frame.size() - 1);
		bytes_sent += frame.size();
		files_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic build_mz();
		logic [31:0] off;
		logic [15:0] mach;
		logic [7:0]  sig [6];
		int          len;
		int          pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			off = $urandom_range(0, 63);
		else if (pick < 8)
			off = $urandom_range(58, 120);
		else if (pick == 8)
			off = $urandom();
		else
			off = $urandom_range(64, 66);
		case ($urandom_range(0, 3))
			0: mach = emc_pkg::MACH_I386;
			1: mach = emc_pkg::MACH_AMD64;
			2: mach = 16'($urandom());
			default: begin
				mach = $urandom_range(0, 1) ? emc_pkg::MACH_I386 : emc_pkg::MACH_AMD64;
				mach = {mach[7:0], mach[15:8]};
			end
		endcase
		sig = '{emc_pkg::PE_P, emc_pkg::PE_E, 8'h00, 8'h00, mach[7:0], mach[15:8]};
		if ($urandom_range(0, 4) == 0)
			sig[$urandom_range(0, 3)] = 8'($urandom());
		pick = $urandom_range(0, 19);
		if (off > 200)
			len = $urandom_range(64, 100);
		else if (pick < 14)
			len = off + 6 + $urandom_range(0, 10);
		else if (pick < 17)
			len = off + $urandom_range(0, 5);
		else
			len = $urandom_range(4, 80);
		// A PE header that sits low only matters once the pointer bytes are in.
		if (off < 58 && len < 64 && pick < 17)
			len = $urandom_range(64, 72);
		if (len < 1)
			len = 1;
		frame.delete();
		repeat (len) frame.push_back(8'($urandom()));
		for (int k = 0; k < emc_pkg::WIN_BYTES; k++)
			if ({32'd0, off} + k < len)
				frame[off + k] = sig[k];
		if ($urandom_range(0, 9) != 0) begin
			frame[0] = emc_pkg::MZ_0;
			if (len > 1)
				frame[1] = emc_pkg::MZ_1;
		end
		for (int k = 0; k < 4; k++)
			if (emc_pkg::PE_PTR_POS + k < len)
				frame[emc_pkg::PE_PTR_POS + k] = off[8*k +: 8];
	endtask

	task automatic build_elf();
		logic [15:0] mach;
		bit          big;
		int          len;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 19) : $urandom_range(20, 48);
		frame.delete();
		repeat (len) frame.push_back(8'($urandom()));
		frame[0] = emc_pkg::ELF_0;
		frame[1] = emc_pkg::ELF_1;
		frame[2] = emc_pkg::ELF_2;
		frame[3] = emc_pkg::ELF_3;
		if ($urandom_range(0, 9) == 0)
			frame[$urandom_range(0, 3)] = 8'($urandom());
		if (len > 5) begin
			case ($urandom_range(0, 2))
				0: frame[5] = ELF_LE;
				1: frame[5] = emc_pkg::ELF_BE;
				default: ;
			endcase
		end
		case ($urandom_range(0, 3))
			0: mach = emc_pkg::ELF_MACH_386;
			1: mach = emc_pkg::ELF_MACH_X64;
			2: mach = 16'($urandom());
			default: begin
				mach = emc_pkg::ELF_MACH_X64;
				mach = {mach[7:0], mach[15:8]};
			end
		endcase
		if (len >= emc_pkg::ELF_MIN) begin
			// Now and then the machine is written in the wrong byte order.
			big = (frame[5] == emc_pkg::ELF_BE) ^ ($urandom_range(0, 7) == 0);
			frame[18] = big ? mach[15:8] : mach[7:0];
			frame[19] = big ? mach[7:0] : mach[15:8];
		end
	endtask

	task automatic build_short();
		int len;
		len = $urandom_range(1, 3);
		frame.delete();
		repeat (len) frame.push_back(8'($urandom()));
		case ($urandom_range(0, 2))
			0: begin
				frame[0] = emc_pkg::MZ_0;
				if (len > 1)
					frame[1] = emc_pkg::MZ_1;
			end
			1: frame[0] = emc_pkg::ELF_0;
			default: ;
		endcase
	endtask

	task automatic build_noise();
		int len;
		len = $urandom_range(4, 90);
		frame.delete();
		repeat (len) frame.push_back(8'($urandom()));
		case ($urandom_range(0, 2))
			0: begin
				frame[0] = emc_pkg::MZ_0;
				frame[1] = emc_pkg::MZ_1 ^ 8'($urandom_range(1, 255));
			end
			1: begin
				frame[0] = emc_pkg::ELF_0;
				frame[1] = emc_pkg::ELF_1;
				frame[2] = emc_pkg::ELF_2;
				frame[3] = emc_pkg::ELF_3 ^ 8'($urandom_range(1, 255));
			end
			default: ;
		endcase
	endtask

	initial begin
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-word files at both byte extremes, the short-file limit,
		// the smallest MZ and ELF files, and a four-byte file of neither kind.
		tx_steady = 1'b1;
		frame.delete();
		frame.push_back(8'h00);
		send_frame();
		frame.delete();
		frame.push_back(8'hFF);
		send_frame();
		frame.delete();
		frame.push_back(emc_pkg::MZ_0);
		frame.push_back(emc_pkg::MZ_1);
		frame.push_back(8'hFF);
		send_frame();
		frame.delete();
		frame.push_back(emc_pkg::MZ_0);
		frame.push_back(emc_pkg::MZ_1);
		frame.push_back(8'h00);
		frame.push_back(8'hFF);
		send_frame();
		frame.delete();
		frame.push_back(emc_pkg::ELF_0);
		frame.push_back(emc_pkg::ELF_1);
		frame.push_back(emc_pkg::ELF_2);
		frame.push_back(emc_pkg::ELF_3);
		send_frame();
		frame.delete();
		frame.push_back(8'hFF);
		frame.push_back(8'h00);
		frame.push_back(8'hFF);
		frame.push_back(8'h00);
		send_frame();
		drain_results();

		while (bytes_sent < 1000) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 8)
				build_mz();
			else if (pick < 15)
				build_elf();
			else if (pick < 17)
				build_short();
			else
				build_noise();
			send_frame();
			if (files_sent % 12 == 0)
				drain_results();
		end

		drain_results();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
